[sv/bmn_pkg.sv]
package bmn_pkg;

    // Fixed field widths
    localparam int NODE_W   = 10;
    localparam int LEN_W    = 16;
    localparam int ACT_W    = 2;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 48;

    localparam logic [TOTAL_W-1:0] SAT48 = {TOTAL_W{1'b1}};

    // Action codes carried on the input word
    localparam logic [ACT_W-1:0] ACT_WEIGHT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EDGE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_ALL,
        OP_CLR_DIST,
        OP_LATCH,
        OP_W_RD,
        OP_W_WR,
        OP_HA_RD,
        OP_EA_WR,
        OP_HB_RD,
        OP_EB_WR,
        OP_C_START,
        OP_S_INIT,
        OP_Q_RD,
        OP_X_RD,
        OP_X_TAKE,
        OP_E_RD,
        OP_Y_RD,
        OP_RELAX,
        OP_X_DONE,
        OP_SUM_START,
        OP_SUM_RD,
        OP_SUM_MUL,
        OP_SUM_ACC,
        OP_SRC_END,
        OP_OUT
    } dp_op_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic clr_last;
        logic a_ok;
        logic edge_ok;
        logic q_empty;
        logic head_valid;
        logic link_valid;
        logic sum_fail;
        logic i_last;
        logic src_last;
        logic last_zero;
        logic out_busy;
    } dp_status_t;

endpackage

[sv/best_meeting_node_shortest_path_core.sv]
// Channel   Direction  Handshake          Word
// s_        in         s_valid/s_ready    s_action, s_node_a, s_node_b, s_edge_length
// m_        out        m_valid/m_ready    m_best_total, m_invalid
// cfg_      in         cfg_we             cfg_wdata (num_nodes)
//
// A weight word is a read-modify-write of the weight memory, and an edge word one of the
// adjacency memory at each end. A compute word is taken and set up, clears the distance
// memory, then per source dequeues each node, walks its arcs and sums the weighted
// distances over the nodes, and at last posts the result.
// After reset the block takes no word while it clears the weight and
// adjacency memories. A stalled result holds in the output register; the block still
// takes new load words while it waits, and a further compute waits to post.
module best_meeting_node_shortest_path_core #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bmn_pkg::NODE_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bmn_pkg::ACT_W-1:0]     s_action,
    input  logic [bmn_pkg::NODE_W-1:0]    s_node_a,
    input  logic [bmn_pkg::NODE_W-1:0]    s_node_b,
    input  logic [bmn_pkg::LEN_W-1:0]     s_edge_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bmn_pkg::TOTAL_W-1:0]   m_best_total,
    output logic                          m_invalid
);

    bmn_pkg::dp_op_t     op;
    bmn_pkg::dp_status_t st;

    // Sequence the work
    bmn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .st       (st),
        .op       (op),
        .s_ready  (s_ready)
    );

    // Hold the graph and run the search
    bmn_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .s_edge_length (s_edge_length),
        .op            (op),
        .st            (st),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_total  (m_best_total),
        .m_invalid     (m_invalid)
    );

`ifndef SYNTH
    // Taking a word leaves the datapath otherwise quiet
    a_ready_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (op == bmn_pkg::OP_NONE || op == bmn_pkg::OP_LATCH))
        else $error("datapath busy while taking a word");

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == bmn_pkg::OP_OUT) |-> !(m_valid && !m_ready))
        else $error("result overwritten");

    // Posting a result raises valid next cycle
    a_post: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == bmn_pkg::OP_OUT) |=> m_valid)
        else $error("result not posted");
`endif

endmodule

[sv/bmn_ctrl.sv]
module bmn_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic [bmn_pkg::ACT_W-1:0]   s_action,
    input  bmn_pkg::dp_status_t         st,
    output bmn_pkg::dp_op_t             op,
    output logic                        s_ready
);

    typedef enum logic [4:0] {
        CLEAR, IDLE, W_RD, W_WR, HA_RD, EA_WR, HB_RD, EB_WR,
        C_START, C_CLR, S_INIT, Q_POP, X_RD, X_TAKE, E_RD, Y_RD, RELAX,
        X_DONE, SUM_START, SUM_RD, SUM_MUL, SUM_ACC, SRC_END, OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == IDLE);

    // Pick the command and the next state
    always_comb begin
        state_next = state_reg;
        op         = bmn_pkg::OP_NONE;
        unique case (state_reg)
            CLEAR: begin
                op = bmn_pkg::OP_CLR_ALL;
                if (st.clr_last) state_next = IDLE;
            end
            IDLE: begin
                if (s_valid) begin
                    op = bmn_pkg::OP_LATCH;
                    case (s_action)
                        bmn_pkg::ACT_WEIGHT:  state_next = W_RD;
                        bmn_pkg::ACT_EDGE:    state_next = HA_RD;
                        bmn_pkg::ACT_COMPUTE: state_next = C_START;
                        default:              state_next = IDLE;
                    endcase
                end
            end
            W_RD: begin
                if (st.a_ok) begin
                    op = bmn_pkg::OP_W_RD;
                    state_next = W_WR;
                end else begin
                    state_next = IDLE;
                end
            end
            W_WR: begin
                op = bmn_pkg::OP_W_WR;
                state_next = IDLE;
            end
            HA_RD: begin
                if (st.edge_ok) begin
                    op = bmn_pkg::OP_HA_RD;
                    state_next = EA_WR;
                end else begin
                    state_next = IDLE;
                end
            end
            EA_WR: begin
                op = bmn_pkg::OP_EA_WR;
                state_next = HB_RD;
            end
            HB_RD: begin
                op = bmn_pkg::OP_HB_RD;
                state_next = EB_WR;
            end
            EB_WR: begin
                op = bmn_pkg::OP_EB_WR;
                state_next = IDLE;
            end
            C_START: begin
                op = bmn_pkg::OP_C_START;
                state_next = C_CLR;
            end
            C_CLR: begin
                op = bmn_pkg::OP_CLR_DIST;
                if (st.clr_last) state_next = st.last_zero ? OUT : S_INIT;
            end
            S_INIT: begin
                op = bmn_pkg::OP_S_INIT;
                state_next = Q_POP;
            end
            Q_POP: begin
                if (st.q_empty) begin
                    state_next = SUM_START;
                end else begin
                    op = bmn_pkg::OP_Q_RD;
                    state_next = X_RD;
                end
            end
            X_RD: begin
                op = bmn_pkg::OP_X_RD;
                state_next = X_TAKE;
            end
            X_TAKE: begin
                op = bmn_pkg::OP_X_TAKE;
                state_next = st.head_valid ? E_RD : X_DONE;
            end
            E_RD: begin
                op = bmn_pkg::OP_E_RD;
                state_next = Y_RD;
            end
            Y_RD: begin
                op = bmn_pkg::OP_Y_RD;
                state_next = RELAX;
            end
            RELAX: begin
                op = bmn_pkg::OP_RELAX;
                state_next = st.link_valid ? E_RD : X_DONE;
            end
            X_DONE: begin
                op = bmn_pkg::OP_X_DONE;
                state_next = Q_POP;
            end
            SUM_START: begin
                op = bmn_pkg::OP_SUM_START;
                state_next = SUM_RD;
            end
            SUM_RD: begin
                op = bmn_pkg::OP_SUM_RD;
                state_next = SUM_MUL;
            end
            SUM_MUL: begin
                op = bmn_pkg::OP_SUM_MUL;
                state_next = st.sum_fail ? SRC_END : SUM_ACC;
            end
            SUM_ACC: begin
                op = bmn_pkg::OP_SUM_ACC;
                state_next = st.i_last ? SRC_END : SUM_RD;
            end
            SRC_END: begin
                op = bmn_pkg::OP_SRC_END;
                state_next = st.src_last ? OUT : S_INIT;
            end
            OUT: begin
                if (!st.out_busy) begin
                    op = bmn_pkg::OP_OUT;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/bmn_datapath.sv]
module bmn_datapath #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bmn_pkg::NODE_W-1:0]    cfg_wdata,
    input  logic [bmn_pkg::NODE_W-1:0]    s_node_a,
    input  logic [bmn_pkg::NODE_W-1:0]    s_node_b,
    input  logic [bmn_pkg::LEN_W-1:0]     s_edge_length,
    input  bmn_pkg::dp_op_t               op,
    output bmn_pkg::dp_status_t           st,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bmn_pkg::TOTAL_W-1:0]   m_best_total,
    output logic                          m_invalid
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int CW  = EW + 1;
    localparam int DW  = NW + 17;
    localparam int PW  = DW + bmn_pkg::WEIGHT_W;
    localparam int XW  = (PW > bmn_pkg::TOTAL_W) ? PW : bmn_pkg::TOTAL_W;
    localparam int QCW = NW + 1;
    localparam int DMW = NW + DW + 1;
    localparam int EMW = NW + bmn_pkg::LEN_W + EW + 1;
    localparam int HMW = EW + 1;
    localparam int TW  = bmn_pkg::TOTAL_W;
    localparam int WW  = bmn_pkg::WEIGHT_W;

    // Memories
    logic [WW-1:0]  weight_mem [MAX_NODES];
    logic [HMW-1:0] head_mem   [MAX_NODES];
    logic [EMW-1:0] edge_mem   [MAX_EDGES];
    logic [DMW-1:0] dist_mem   [MAX_NODES];
    logic [NW-1:0]  queue_mem  [MAX_NODES];

    logic [WW-1:0]  w_rdata;
    logic [HMW-1:0] h_rdata;
    logic [EMW-1:0] e_rdata;
    logic [DMW-1:0] d_rdata;
    logic [NW-1:0]  q_rdata;

    logic           w_we, h_we, e_we, d_we, q_we;
    logic [NW-1:0]  w_waddr, w_raddr, h_waddr, h_raddr, d_waddr, d_raddr, q_waddr, q_raddr;
    logic [EW-1:0]  e_waddr, e_raddr;
    logic [WW-1:0]  w_wdata;
    logic [HMW-1:0] h_wdata;
    logic [EMW-1:0] e_wdata;
    logic [DMW-1:0] d_wdata;
    logic [NW-1:0]  q_wdata;

    // Registers
    logic [bmn_pkg::NODE_W-1:0] num_nodes_reg;
    logic [bmn_pkg::NODE_W-1:0] a_reg, b_reg;
    logic [bmn_pkg::LEN_W-1:0]  len_reg;
    logic [NW-1:0]              clr_reg;
    logic [CW-1:0]              edge_cnt_reg;
    logic [NW-1:0]              last_reg, src_reg, i_reg;
    logic                       found_reg, ok_reg;
    logic [TW-1:0]              best_reg, sum_reg;
    logic [PW-1:0]              prod_reg;
    logic [NW-1:0]              x_reg, y_reg;
    logic [DW-1:0]              dx_reg;
    logic [EW-1:0]              cur_reg;
    logic [bmn_pkg::LEN_W-1:0]  ylen_reg;
    logic                       lv_reg;
    logic [NW-1:0]              qh_reg, qt_reg;
    logic [QCW-1:0]             qcnt_reg;
    logic                       m_valid_reg, m_invalid_reg;
    logic [TW-1:0]              m_total_reg;

    // Decoded fields
    logic [NW-1:0]              a_idx, b_idx;
    logic                       a_ok, b_ok, room;
    logic [NW-1:0]              d_ep;
    logic [DW-1:0]              d_dist;
    logic                       d_inq;
    logic [NW-1:0]              e_tgt;
    logic [bmn_pkg::LEN_W-1:0]  e_len;
    logic [EW-1:0]              e_link;
    logic                       e_lv;
    logic [DW-1:0]              nd;
    logic                       upd;
    logic [XW-1:0]              p_x;
    logic [TW-1:0]              p_sat, sum_n;
    logic [TW:0]                sum_x;
    logic [NW-1:0]              last_n;

    function automatic logic [NW-1:0] ptr_inc(input logic [NW-1:0] p);
        ptr_inc = (32'(p) == MAX_NODES - 1) ? '0 : p + NW'(1);
    endfunction

    assign a_idx  = NW'(a_reg);
    assign b_idx  = NW'(b_reg);
    assign a_ok   = 32'(a_reg) < MAX_NODES;
    assign b_ok   = 32'(b_reg) < MAX_NODES;
    assign room   = 32'(edge_cnt_reg) <= MAX_EDGES - 2;

    assign d_ep   = d_rdata[DMW-1 -: NW];
    assign d_dist = d_rdata[DW:1];
    assign d_inq  = d_rdata[0];
    assign e_tgt  = e_rdata[EMW-1 -: NW];
    assign e_len  = e_rdata[EW+1 +: bmn_pkg::LEN_W];
    assign e_link = e_rdata[1 +: EW];
    assign e_lv   = e_rdata[0];

    // Relaxation of one arc
    assign nd  = dx_reg + DW'(ylen_reg);
    assign upd = (d_ep != src_reg) || (nd < d_dist);

    // Saturating accumulate
    assign p_x   = XW'(prod_reg);
    assign p_sat = (p_x > XW'(bmn_pkg::SAT48)) ? bmn_pkg::SAT48 : p_x[TW-1:0];
    assign sum_x = {1'b0, sum_reg} + {1'b0, p_sat};
    assign sum_n = sum_x[TW] ? bmn_pkg::SAT48 : sum_x[TW-1:0];

    assign last_n = (32'(num_nodes_reg) > MAX_NODES - 1) ? NW'(MAX_NODES - 1)
                                                         : NW'(num_nodes_reg);

    // Status
    assign st.clr_last   = (32'(clr_reg) == MAX_NODES - 1);
    assign st.a_ok       = a_ok;
    assign st.edge_ok    = a_ok && b_ok && room;
    assign st.q_empty    = (qcnt_reg == '0);
    assign st.head_valid = h_rdata[EW];
    assign st.link_valid = lv_reg;
    assign st.sum_fail   = (w_rdata != '0) && (d_ep != src_reg);
    assign st.i_last     = (i_reg == last_reg);
    assign st.src_last   = (src_reg == last_reg);
    assign st.last_zero  = (last_reg == '0);
    assign st.out_busy   = m_valid_reg && !m_ready;

    assign m_valid      = m_valid_reg;
    assign m_best_total = m_total_reg;
    assign m_invalid    = m_invalid_reg;

    // Steer memory ports
    always_comb begin
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;
        h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
        e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
        d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        case (op)
            bmn_pkg::OP_CLR_ALL: begin
                w_we = 1'b1; w_waddr = clr_reg;
                h_we = 1'b1; h_waddr = clr_reg;
                d_we = 1'b1; d_waddr = clr_reg;
            end
            bmn_pkg::OP_CLR_DIST: begin
                d_we = 1'b1; d_waddr = clr_reg;
            end
            bmn_pkg::OP_W_RD: w_raddr = a_idx;
            bmn_pkg::OP_W_WR: begin
                w_we    = (w_rdata != {WW{1'b1}});
                w_waddr = a_idx;
                w_wdata = w_rdata + WW'(1);
            end
            bmn_pkg::OP_HA_RD: h_raddr = a_idx;
            bmn_pkg::OP_EA_WR: begin
                e_we    = 1'b1;
                e_waddr = EW'(edge_cnt_reg);
                e_wdata = {b_idx, len_reg, h_rdata[EW-1:0], h_rdata[EW]};
                h_we    = 1'b1;
                h_waddr = a_idx;
                h_wdata = {1'b1, EW'(edge_cnt_reg)};
            end
            bmn_pkg::OP_HB_RD: h_raddr = b_idx;
            bmn_pkg::OP_EB_WR: begin
                e_we    = 1'b1;
                e_waddr = EW'(edge_cnt_reg);
                e_wdata = {a_idx, len_reg, h_rdata[EW-1:0], h_rdata[EW]};
                h_we    = 1'b1;
                h_waddr = b_idx;
                h_wdata = {1'b1, EW'(edge_cnt_reg)};
            end
            bmn_pkg::OP_S_INIT: begin
                d_we = 1'b1; d_waddr = src_reg; d_wdata = {src_reg, DW'(0), 1'b1};
                q_we = 1'b1; q_waddr = '0;      q_wdata = src_reg;
            end
            bmn_pkg::OP_Q_RD: q_raddr = qh_reg;
            bmn_pkg::OP_X_RD: begin
                d_raddr = q_rdata;
                h_raddr = q_rdata;
            end
            bmn_pkg::OP_E_RD: e_raddr = cur_reg;
            bmn_pkg::OP_Y_RD: d_raddr = e_tgt;
            bmn_pkg::OP_RELAX: begin
                d_we    = upd;
                d_waddr = y_reg;
                d_wdata = {src_reg, nd, 1'b1};
                q_we    = upd && !d_inq;
                q_waddr = qt_reg;
                q_wdata = y_reg;
            end
            bmn_pkg::OP_X_DONE: begin
                d_we = 1'b1; d_waddr = x_reg; d_wdata = {src_reg, dx_reg, 1'b0};
            end
            bmn_pkg::OP_SUM_RD: begin
                w_raddr = i_reg;
                d_raddr = i_reg;
            end
            default: ;
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (w_we) weight_mem[w_waddr] <= w_wdata;
        if (h_we) head_mem[h_waddr]   <= h_wdata;
        if (e_we) edge_mem[e_waddr]   <= e_wdata;
        if (d_we) dist_mem[d_waddr]   <= d_wdata;
        if (q_we) queue_mem[q_waddr]  <= q_wdata;
        w_rdata <= weight_mem[w_raddr];
        h_rdata <= head_mem[h_raddr];
        e_rdata <= edge_mem[e_raddr];
        d_rdata <= dist_mem[d_raddr];
        q_rdata <= queue_mem[q_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_nodes_reg <= bmn_pkg::NODE_W'(1);
            clr_reg       <= '0;
            edge_cnt_reg  <= '0;
            qcnt_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) num_nodes_reg <= cfg_wdata;
            // Post a new result, or drop the one just taken
            if (op == bmn_pkg::OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (op)
                bmn_pkg::OP_CLR_ALL, bmn_pkg::OP_CLR_DIST: clr_reg <= ptr_inc(clr_reg);
                bmn_pkg::OP_EA_WR, bmn_pkg::OP_EB_WR: edge_cnt_reg <= edge_cnt_reg + CW'(1);
                bmn_pkg::OP_S_INIT: qcnt_reg <= QCW'(1);
                bmn_pkg::OP_Q_RD:   qcnt_reg <= qcnt_reg - QCW'(1);
                bmn_pkg::OP_RELAX:  if (upd && !d_inq) qcnt_reg <= qcnt_reg + QCW'(1);
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (op)
            bmn_pkg::OP_LATCH: begin
                a_reg   <= s_node_a;
                b_reg   <= s_node_b;
                len_reg <= s_edge_length;
            end
            bmn_pkg::OP_C_START: begin
                last_reg  <= last_n;
                src_reg   <= NW'(1);
                found_reg <= 1'b0;
                best_reg  <= '0;
            end
            bmn_pkg::OP_S_INIT: begin
                qh_reg <= '0;
                qt_reg <= ptr_inc('0);
            end
            bmn_pkg::OP_Q_RD: qh_reg <= ptr_inc(qh_reg);
            bmn_pkg::OP_X_RD: x_reg <= q_rdata;
            bmn_pkg::OP_X_TAKE: begin
                dx_reg  <= d_dist;
                cur_reg <= h_rdata[EW-1:0];
            end
            bmn_pkg::OP_Y_RD: begin
                y_reg    <= e_tgt;
                ylen_reg <= e_len;
                cur_reg  <= e_link;
                lv_reg   <= e_lv;
            end
            bmn_pkg::OP_RELAX: if (upd && !d_inq) qt_reg <= ptr_inc(qt_reg);
            bmn_pkg::OP_SUM_START: begin
                i_reg   <= NW'(1);
                sum_reg <= '0;
                ok_reg  <= 1'b1;
            end
            bmn_pkg::OP_SUM_MUL: begin
                prod_reg <= PW'(d_dist) * PW'(w_rdata);
                if (st.sum_fail) ok_reg <= 1'b0;
            end
            bmn_pkg::OP_SUM_ACC: begin
                sum_reg <= sum_n;
                i_reg   <= i_reg + NW'(1);
            end
            bmn_pkg::OP_SRC_END: begin
                if (ok_reg && (!found_reg || sum_reg < best_reg)) begin
                    best_reg  <= sum_reg;
                    found_reg <= 1'b1;
                end
                src_reg <= src_reg + NW'(1);
            end
            bmn_pkg::OP_OUT: begin
                m_total_reg   <= found_reg ? best_reg : '0;
                m_invalid_reg <= !found_reg;
            end
            default: ;
        endcase
    end

endmodule
